[hw/rtl/ibfr_pkg.sv]
// Shared types and constants of the iBUS frame receiver.
// Used by ibfr_ctrl, ibfr_dp and ibus_frame_receiver_unit; no dependencies.
`default_nettype none

package ibfr_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 4;
    localparam int ROW_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    localparam logic [7:0]  HDR_LEN  = 8'h20;
    localparam logic [7:0]  HDR_CMD  = 8'h40;
    localparam logic [15:0] SUM_INIT = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_MAX  = 2'd2;

    localparam logic [31:0] RST_TIMEOUT = 32'd100000;
    localparam logic [11:0] RST_CH_MIN  = 12'd750;
    localparam logic [11:0] RST_CH_MAX  = 12'd2250;

    localparam logic [2:0] EV_CHAN = 3'd0;
    localparam logic [2:0] EV_LEN  = 3'd1;
    localparam logic [2:0] EV_HDR  = 3'd2;
    localparam logic [2:0] EV_CRC  = 3'd3;
    localparam logic [2:0] EV_RNG  = 3'd4;
    localparam logic [2:0] EV_TICK = 3'd5;
    localparam logic [2:0] EV_LOST = 3'd6;

    typedef struct packed {
        logic            latch;
        logic            apply;
        logic            rng_fail;
        logic            good;
        logic            rd_en;
        logic            emit_evt;
        logic            emit_chan;
        logic            last;
        logic [CH_W-1:0] ch;
    } t_ctrl_cmd;

    typedef struct packed {
        logic has_event;
        logic frame_good;
        logic in_range;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/ibfr_ctrl.sv]
// Sequencer of the iBUS frame receiver: item intake, range-check and channel loops.
// Depends on ibfr_pkg; drives ibfr_dp through t_ctrl_cmd.
`default_nettype none

module ibfr_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ibfr_pkg::t_dp_status i_status,
    output ibfr_pkg::t_ctrl_cmd  o_cmd
);
    import ibfr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_RRD   = 3'd3;
    localparam logic [2:0] S_RCMP  = 3'd4;
    localparam logic [2:0] S_CRD   = 3'd5;
    localparam logic [2:0] S_CEMIT = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;

    always_comb begin
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        n_state  = r_state;
        n_ch     = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.apply = 1'b1;
                if (i_status.frame_good) begin
                    n_ch    = '0;
                    n_state = S_RRD;
                end else if (i_status.has_event) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_evt = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RCMP;
            end
            S_RCMP: begin
                if (!i_status.in_range) begin
                    o_cmd.rng_fail = 1'b1;
                    n_state        = S_EMIT;
                end else if (r_ch == CH_LAST) begin
                    o_cmd.good = 1'b1;
                    n_ch       = '0;
                    n_state    = S_CRD;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_RRD;
                end
            end
            S_CRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CEMIT;
            end
            S_CEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_chan = 1'b1;
                    o_cmd.last      = (r_ch == CH_LAST);
                    if (r_ch == CH_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_CRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ibfr_dp.sv]
// Datapath of the iBUS frame receiver: parser state, frame store, checksum,
// link age, counters, configuration and output register. Depends on ibfr_pkg.
`default_nettype none

module ibfr_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cmd,
    input  wire  [7:0]                       i_data_byte,
    input  wire                              i_cfg_we,
    input  wire  [ibfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [ibfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  ibfr_pkg::t_ctrl_cmd              i_ctl,
    output ibfr_pkg::t_dp_status             o_status,
    input  wire                              i_out_stall,
    output logic                             o_out_valid,
    output logic [2:0]                       o_event_res,
    output logic [3:0]                       o_channel_index,
    output logic [11:0]                      o_channel_value,
    output logic                             o_link_alive,
    output logic                             o_recovered,
    output logic [31:0]                      o_frame_age_ticks,
    output logic [31:0]                      o_valid_frame_count,
    output logic [31:0]                      o_checksum_error_count,
    output logic [31:0]                      o_header_error_count,
    output logic [31:0]                      o_length_error_count,
    output logic [31:0]                      o_range_error_count,
    output logic                             o_last
);
    import ibfr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [4:0] POS_SUM_END = 5'd30;
    localparam logic [4:0] POS_LAST    = 5'd31;

    logic [15:0] r_mem [0:(1<<ROW_W)-1];
    logic [15:0] r_rd_data;

    logic [31:0] r_timeout;
    logic [11:0] r_cmin, r_cmax;

    logic        r_cmd_q;
    logic [7:0]  r_byte_q;
    logic [7:0]  r_lo, n_lo;
    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [31:0] r_age, n_age;
    logic        r_alive, n_alive;
    logic        r_seen, n_seen;
    logic        r_rec, n_rec;
    logic [2:0]  r_event, n_event;
    logic [31:0] r_good, n_good;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_hdr, n_hdr;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rng, n_rng;

    logic        frame_end;
    logic        crc_ok;
    logic        mem_we;
    logic [31:0] age_inc;
    logic [11:0] rd_val;
    logic [ROW_W-1:0] rd_row;

    assign frame_end = !r_cmd_q && (r_phase == PH_BODY) && (r_pos == POS_LAST);
    assign crc_ok    = (r_sum == {r_byte_q, r_lo});
    assign age_inc   = r_age + 32'd1;
    assign rd_val    = r_rd_data[11:0];
    assign rd_row    = ROW_W'(i_ctl.ch) + 1'b1;
    assign mem_we    = i_ctl.apply && !r_cmd_q && (r_phase == PH_BODY) && r_pos[0]
                       && (r_pos != POS_LAST);

    always_comb begin
        o_status.frame_good = frame_end && crc_ok;
        o_status.has_event  = r_cmd_q || (frame_end && !crc_ok)
                              || ((r_phase == PH_HUNT) && (r_byte_q != HDR_LEN))
                              || ((r_phase == PH_CMD) && (r_byte_q != HDR_CMD));
        o_status.in_range   = !((rd_val < r_cmin) || (rd_val > r_cmax));
        o_status.out_free   = !o_out_valid || !i_out_stall;
    end

    always_comb begin
        n_lo    = r_lo;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_age   = r_age;
        n_alive = r_alive;
        n_seen  = r_seen;
        n_rec   = r_rec;
        n_event = r_event;
        n_good  = r_good;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_rng   = r_rng;
        if (i_ctl.apply) begin
            if (r_cmd_q) begin
                n_event = EV_TICK;
                if (r_seen) begin
                    n_age = age_inc;
                    if (r_alive && (age_inc >= r_timeout)) begin
                        n_alive = 1'b0;
                        n_event = EV_LOST;
                    end
                end else begin
                    n_age = '0;
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (r_byte_q == HDR_LEN) begin
                            n_pos   = 5'd1;
                            n_sum   = SUM_INIT - {8'd0, HDR_LEN};
                            n_phase = PH_CMD;
                        end else begin
                            n_len   = r_len + 32'd1;
                            n_pos   = '0;
                            n_event = EV_LEN;
                        end
                    end
                    PH_CMD: begin
                        if (r_byte_q == HDR_CMD) begin
                            n_pos   = 5'd2;
                            n_sum   = r_sum - {8'd0, r_byte_q};
                            n_phase = PH_BODY;
                        end else begin
                            n_hdr   = r_hdr + 32'd1;
                            n_event = EV_HDR;
                            if (r_byte_q == HDR_LEN) begin
                                n_pos = 5'd1;
                                n_sum = SUM_INIT - {8'd0, HDR_LEN};
                            end else begin
                                n_pos   = '0;
                                n_phase = PH_HUNT;
                            end
                        end
                    end
                    default: begin
                        if (!r_pos[0]) begin
                            n_lo = r_byte_q;
                        end
                        if (r_pos < POS_SUM_END) begin
                            n_sum = r_sum - {8'd0, r_byte_q};
                        end
                        if (r_pos == POS_LAST) begin
                            n_pos   = '0;
                            n_phase = PH_HUNT;
                            if (!crc_ok) begin
                                n_crc   = r_crc + 32'd1;
                                n_event = EV_CRC;
                            end
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                endcase
            end
        end
        if (i_ctl.rng_fail) begin
            n_rng   = r_rng + 32'd1;
            n_event = EV_RNG;
        end
        if (i_ctl.good) begin
            n_rec   = r_seen && !r_alive;
            n_good  = r_good + 32'd1;
            n_age   = '0;
            n_seen  = 1'b1;
            n_alive = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos[4:1]] <= {r_byte_q, r_lo};
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd_q  <= i_cmd;
            r_byte_q <= i_data_byte;
        end
        r_lo    <= n_lo;
        r_rec   <= n_rec;
        r_event <= n_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= RST_TIMEOUT;
            r_cmin    <= RST_CH_MIN;
            r_cmax    <= RST_CH_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_CH_MIN:  r_cmin    <= i_cfg_data[11:0];
                CFG_CH_MAX:  r_cmax    <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_sum   <= SUM_INIT;
            r_age   <= '0;
            r_alive <= 1'b0;
            r_seen  <= 1'b0;
            r_good  <= '0;
            r_crc   <= '0;
            r_hdr   <= '0;
            r_len   <= '0;
            r_rng   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_age   <= n_age;
            r_alive <= n_alive;
            r_seen  <= n_seen;
            r_good  <= n_good;
            r_crc   <= n_crc;
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_rng   <= n_rng;
        end
    end

    // snapshot state into the output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_evt || i_ctl.emit_chan) begin
            o_link_alive           <= r_alive;
            o_frame_age_ticks      <= r_age;
            o_valid_frame_count    <= r_good;
            o_checksum_error_count <= r_crc;
            o_header_error_count   <= r_hdr;
            o_length_error_count   <= r_len;
            o_range_error_count    <= r_rng;
        end
        if (i_ctl.emit_evt) begin
            o_event_res     <= r_event;
            o_channel_index <= '0;
            o_channel_value <= '0;
            o_recovered     <= 1'b0;
            o_last          <= 1'b1;
        end else if (i_ctl.emit_chan) begin
            o_event_res     <= EV_CHAN;
            o_channel_index <= i_ctl.ch;
            o_channel_value <= rd_val;
            o_recovered     <= r_rec;
            o_last          <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctl.emit_evt || i_ctl.emit_chan) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ibus_frame_receiver_unit.sv]
// Top level of the iBUS frame receiver: joins the sequencer and the datapath.
// Depends on ibfr_pkg, ibfr_ctrl and ibfr_dp.
//
// One input transaction at a time: a byte that gives no result is latched and
// applied, a tick or a byte with a single error result is also emitted, after
// any wait on the output stall. The 32nd byte of a frame with a good checksum
// runs the range check and then the channel results out of the frame store,
// one 16-bit row read per channel and pass on its single read port, for the
// 8 channels. A new input transaction is taken while the last result still
// waits in the output register. Configuration writes are registered from
// i_cfg_we and belong to idle periods.
`default_nettype none

module ibus_frame_receiver_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_cmd,
    input  wire  [7:0]                       i_data_byte,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [2:0]                       o_event_res,
    output logic [3:0]                       o_channel_index,
    output logic [11:0]                      o_channel_value,
    output logic                             o_link_alive,
    output logic                             o_recovered,
    output logic [31:0]                      o_frame_age_ticks,
    output logic [31:0]                      o_valid_frame_count,
    output logic [31:0]                      o_checksum_error_count,
    output logic [31:0]                      o_header_error_count,
    output logic [31:0]                      o_length_error_count,
    output logic [31:0]                      o_range_error_count,
    output logic                             o_last,
    input  wire                              i_cfg_we,
    input  wire  [ibfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [ibfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ibfr_pkg::*;

    t_ctrl_cmd  ctl;
    t_dp_status status;

    ibfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (ctl)
    );

    ibfr_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (i_cmd),
        .i_data_byte            (i_data_byte),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_ctl                  (ctl),
        .o_status               (status),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_event_res            (o_event_res),
        .o_channel_index        (o_channel_index),
        .o_channel_value        (o_channel_value),
        .o_link_alive           (o_link_alive),
        .o_recovered            (o_recovered),
        .o_frame_age_ticks      (o_frame_age_ticks),
        .o_valid_frame_count    (o_valid_frame_count),
        .o_checksum_error_count (o_checksum_error_count),
        .o_header_error_count   (o_header_error_count),
        .o_length_error_count   (o_length_error_count),
        .o_range_error_count    (o_range_error_count),
        .o_last                 (o_last)
    );

endmodule

`default_nettype wire

[tb/tb_ibus_frame_receiver_unit.sv]
// Self-checking testbench of ibus_frame_receiver_unit: byte and tick traffic
// with directed and random frames, checked against an in-bench frame parser.
// Depends on ibfr_pkg and the ibus_frame_receiver_unit RTL.
`timescale 1ns / 100ps

module tb_ibus_frame_receiver_unit;

    import ibfr_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int NUM_PHASES = 5;

    typedef enum logic [1:0] {HUNT_LEN, HUNT_CMD, IN_BODY} t_rx_phase;
    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_RANGE} t_frame_kind;

    typedef struct packed {
        logic       tick;
        logic [7:0] data;
    } t_rx_item;

    typedef struct packed {
        logic [2:0]  evt;
        logic [3:0]  idx;
        logic [11:0] val;
        logic        alive;
        logic        rec;
        logic [31:0] age;
        logic [31:0] good;
        logic [31:0] crc;
        logic [31:0] hdr;
        logic [31:0] len;
        logic [31:0] rng;
        logic        last;
    } t_rx_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_event_res;
    logic [3:0]  o_channel_index;
    logic [11:0] o_channel_value;
    logic        o_link_alive;
    logic        o_recovered;
    logic [31:0] o_frame_age_ticks;
    logic [31:0] o_valid_frame_count;
    logic [31:0] o_checksum_error_count;
    logic [31:0] o_header_error_count;
    logic [31:0] o_length_error_count;
    logic [31:0] o_range_error_count;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ibus_frame_receiver_unit u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_cmd                  (i_cmd),
        .i_data_byte            (i_data_byte),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_event_res            (o_event_res),
        .o_channel_index        (o_channel_index),
        .o_channel_value        (o_channel_value),
        .o_link_alive           (o_link_alive),
        .o_recovered            (o_recovered),
        .o_frame_age_ticks      (o_frame_age_ticks),
        .o_valid_frame_count    (o_valid_frame_count),
        .o_checksum_error_count (o_checksum_error_count),
        .o_header_error_count   (o_header_error_count),
        .o_length_error_count   (o_length_error_count),
        .o_range_error_count    (o_range_error_count),
        .o_last                 (o_last),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    t_rx_item   rx_items[$];
    t_rx_report rx_reports[$];

    logic [31:0] lim_timeout;
    logic [11:0] lim_min;
    logic [11:0] lim_max;

    t_rx_phase   rx_phase;
    logic [5:0]  rx_pos;
    logic [7:0]  rx_store [32];
    logic [15:0] rx_sum;
    logic [31:0] link_age;
    logic        link_up;
    logic        link_seen;
    logic [31:0] cnt_good, cnt_crc, cnt_hdr, cnt_len, cnt_rng;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int queued_total = 0;
    int n_taken = 0;
    int n_checked = 0;
    int n_drops = 0;
    int n_recover = 0;
    int errors = 0;
    int cycle_count = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void add_report(logic [2:0] evt, logic [3:0] idx, logic [11:0] val,
                                       logic rec);
        t_rx_report r;
        r.evt   = evt;
        r.idx   = idx;
        r.val   = val;
        r.alive = link_up;
        r.rec   = rec;
        r.age   = link_age;
        r.good  = cnt_good;
        r.crc   = cnt_crc;
        r.hdr   = cnt_hdr;
        r.len   = cnt_len;
        r.rng   = cnt_rng;
        r.last  = 1'b0;
        rx_reports.push_back(r);
    endfunction

    function automatic logic [11:0] stored_channel(int c);
        return {rx_store[3 + 2 * c][3:0], rx_store[2 + 2 * c]};
    endfunction

    function automatic void close_frame();
        logic [11:0] v;
        logic        rec;
        if (rx_sum != {rx_store[31], rx_store[30]}) begin
            cnt_crc++;
            add_report(EV_CRC, 4'd0, 12'd0, 1'b0);
            return;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            v = stored_channel(c);
            if (v < lim_min || v > lim_max) begin
                cnt_rng++;
                add_report(EV_RNG, 4'd0, 12'd0, 1'b0);
                return;
            end
        end
        rec = link_seen && !link_up;
        if (rec)
            n_recover++;
        cnt_good++;
        link_age  = '0;
        link_seen = 1'b1;
        link_up   = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
            add_report(EV_CHAN, 4'(c), stored_channel(c), rec);
    endfunction

    function automatic void start_frame();
        rx_store[0] = HDR_LEN;
        rx_pos      = 6'd1;
        rx_sum      = SUM_INIT - 16'(HDR_LEN);
    endfunction

    function automatic void parse_rx_item(t_rx_item it);
        int         n_before;
        logic [2:0] evt;
        t_rx_report tail;
        n_before = rx_reports.size();
        if (it.tick) begin
            evt = EV_TICK;
            if (link_seen) begin
                link_age++;
                if (link_up && link_age >= lim_timeout) begin
                    link_up = 1'b0;
                    evt = EV_LOST;
                    n_drops++;
                end
            end else begin
                link_age = '0;
            end
            add_report(evt, 4'd0, 12'd0, 1'b0);
        end else begin
            case (rx_phase)
                HUNT_CMD: begin
                    if (it.data == HDR_CMD) begin
                        rx_store[1] = it.data;
                        rx_pos      = 6'd2;
                        rx_sum      = rx_sum - 16'(it.data);
                        rx_phase    = IN_BODY;
                    end else begin
                        cnt_hdr++;
                        if (it.data == HDR_LEN) begin
                            start_frame();
                        end else begin
                            rx_pos   = '0;
                            rx_phase = HUNT_LEN;
                        end
                        add_report(EV_HDR, 4'd0, 12'd0, 1'b0);
                    end
                end
                IN_BODY: begin
                    rx_store[rx_pos[4:0]] = it.data;
                    if (rx_pos < 6'd30)
                        rx_sum = rx_sum - 16'(it.data);
                    rx_pos++;
                    if (rx_pos >= 6'd32) begin
                        close_frame();
                        rx_pos   = '0;
                        rx_phase = HUNT_LEN;
                    end
                end
                default: begin
                    if (it.data == HDR_LEN) begin
                        start_frame();
                        rx_phase = HUNT_CMD;
                    end else begin
                        cnt_len++;
                        rx_pos   = '0;
                        rx_phase = HUNT_LEN;
                        add_report(EV_LEN, 4'd0, 12'd0, 1'b0);
                    end
                end
            endcase
        end
        if (rx_reports.size() > n_before) begin
            tail = rx_reports.pop_back();
            tail.last = 1'b1;
            rx_reports.push_back(tail);
        end
    endfunction

    function automatic void push_item(logic tick, logic [7:0] data);
        t_rx_item it;
        it.tick = tick;
        it.data = data;
        rx_items.push_back(it);
        queued_total++;
    endfunction

    function automatic logic [11:0] pick_channel(logic out_of_range);
        if (out_of_range) begin
            if (lim_min > 0 && (lim_max == 12'hFFF || $urandom_range(1) == 0))
                return 12'($urandom_range(lim_min - 1, 0));
            if (lim_max < 12'hFFF)
                return 12'($urandom_range(12'hFFF, lim_max + 1));
            return 12'($urandom);
        end
        if (lim_min > lim_max)
            return 12'($urandom);
        case ($urandom_range(3))
            0: return lim_min;
            1: return lim_max;
            default: return 12'($urandom_range(lim_max, lim_min));
        endcase
    endfunction

    // push bytes first..cut-1 of a frame with random content
    function automatic void add_frame(t_frame_kind kind, int first, int cut);
        logic [7:0]  fb [32];
        logic [15:0] s;
        logic [11:0] v;
        int          bad_ch;
        fb[0] = HDR_LEN;
        fb[1] = HDR_CMD;
        for (int i = 2; i < 32; i++)
            fb[i] = 8'($urandom);
        bad_ch = (kind == FR_BAD_RANGE) ? int'($urandom_range(CHANNELS - 1)) : -1;
        for (int c = 0; c < CHANNELS; c++) begin
            v = pick_channel(c == bad_ch);
            fb[2 + 2 * c] = v[7:0];
            fb[3 + 2 * c] = {fb[3 + 2 * c][7:4], v[11:8]};
        end
        s = SUM_INIT;
        for (int i = 0; i < 30; i++)
            s = s - 16'(fb[i]);
        if (kind == FR_BAD_SUM)
            s = s ^ 16'($urandom_range(16'hFFFF, 1));
        fb[30] = s[7:0];
        fb[31] = s[15:8];
        for (int i = first; i < cut; i++)
            push_item(1'b0, fb[i]);
    endfunction

    function automatic void add_random_traffic(int n);
        int goal;
        int r;
        goal = queued_total + n;
        while (queued_total < goal) begin
            r = $urandom_range(99);
            if (r < 60) begin
                r = $urandom_range(99);
                add_frame(r < 70 ? FR_GOOD : (r < 85 ? FR_BAD_SUM : FR_BAD_RANGE), 0, 32);
            end else if (r < 75) begin
                repeat ($urandom_range(4, 1)) push_item(1'b1, 8'($urandom));
            end else if (r < 85) begin
                repeat ($urandom_range(3, 1)) push_item(1'b0, 8'($urandom));
            end else if (r < 93) begin
                push_item(1'b0, HDR_LEN);
                push_item(1'b0, $urandom_range(1) ? HDR_LEN : 8'($urandom));
            end else begin
                add_frame(FR_GOOD, 0, $urandom_range(31, 2));
            end
        end
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_TIMEOUT: lim_timeout = data;
            CFG_CH_MIN:  lim_min = data[11:0];
            CFG_CH_MAX:  lim_max = data[11:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rx_items.size() != 0 || i_in_valid || rx_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 20)
                $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // driver: present queued transactions, predict on acceptance
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_rx_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                it.tick = i_cmd;
                it.data = i_data_byte;
                parse_rx_item(it);
                n_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = rx_items.pop_front();
                i_cmd       <= it.tick;
                i_data_byte <= it.data;
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_rx_report want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (rx_reports.size() == 0) begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t unexpected result: expected none, actual event %0d",
                                 $time, o_event_res);
                end else begin
                    want = rx_reports.pop_front();
                    n_checked++;
                    cmp("event_res", 32'(want.evt), 32'(o_event_res));
                    cmp("channel_index", 32'(want.idx), 32'(o_channel_index));
                    cmp("channel_value", 32'(want.val), 32'(o_channel_value));
                    cmp("link_alive", 32'(want.alive), 32'(o_link_alive));
                    cmp("recovered", 32'(want.rec), 32'(o_recovered));
                    cmp("frame_age_ticks", want.age, o_frame_age_ticks);
                    cmp("valid_frame_count", want.good, o_valid_frame_count);
                    cmp("checksum_error_count", want.crc, o_checksum_error_count);
                    cmp("header_error_count", want.hdr, o_header_error_count);
                    cmp("length_error_count", want.len, o_length_error_count);
                    cmp("range_error_count", want.rng, o_range_error_count);
                    cmp("last", 32'(want.last), 32'(o_last));
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb_ibus_frame_receiver_unit failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] ph_timeout [NUM_PHASES];
        logic [11:0] ph_min [NUM_PHASES];
        logic [11:0] ph_max [NUM_PHASES];
        int          ph_send [4];
        int          ph_stall [4];
        ph_timeout = '{RST_TIMEOUT, 32'd1, 32'd3, 32'hFFFF_FFFF, 32'd2};
        ph_min     = '{RST_CH_MIN, 12'd0, 12'd2000, 12'hFFF, 12'd0};
        ph_max     = '{RST_CH_MAX, 12'hFFF, 12'd1000, 12'hFFF, 12'd0};
        ph_send    = '{0, 80, 0, 13};
        ph_stall   = '{0, 0, 80, 13};

        lim_timeout = RST_TIMEOUT;
        lim_min     = RST_CH_MIN;
        lim_max     = RST_CH_MAX;
        rx_phase    = HUNT_LEN;
        rx_pos      = '0;
        rx_sum      = SUM_INIT;
        link_age    = '0;
        link_up     = 1'b0;
        link_seen   = 1'b0;
        cnt_good = '0;
        cnt_crc  = '0;
        cnt_hdr  = '0;
        cnt_len  = '0;
        cnt_rng  = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                repeat (60) @(posedge i_clk);
                cfg_write(CFG_TIMEOUT, ph_timeout[p]);
                cfg_write(CFG_CH_MIN, 32'(ph_min[p]));
                cfg_write(CFG_CH_MAX, 32'(ph_max[p]));
            end
            send_idle_pct = ph_send[p % 4];
            stall_pct     = ph_stall[p % 4];
            if (p == 0) begin
                // tick before any frame, stray bytes, bad second header bytes
                push_item(1'b1, 8'hFF);
                push_item(1'b0, 8'h00);
                push_item(1'b0, 8'hFF);
                push_item(1'b0, HDR_LEN);
                push_item(1'b0, 8'h55);
                push_item(1'b0, HDR_LEN);
                add_frame(FR_GOOD, 0, 32);
                push_item(1'b1, 8'h00);
                add_frame(FR_BAD_SUM, 0, 32);
                add_frame(FR_BAD_RANGE, 0, 32);
            end else if (p == 1) begin
                // drop the link on the next tick, then recover it
                add_frame(FR_GOOD, 0, 32);
                push_item(1'b1, 8'h00);
                push_item(1'b1, 8'hFF);
                add_frame(FR_GOOD, 0, 32);
            end
            add_random_traffic(14);
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Run covered %0d input transactions and %0d checked results over %0d settings.",
                 n_taken, n_checked, NUM_PHASES);
        $display("Good frames %0d, link drops %0d, recoveries %0d.",
                 cnt_good, n_drops, n_recover);
        if (errors == 0)
            $display("tb_ibus_frame_receiver_unit passed");
        else
            $display("tb_ibus_frame_receiver_unit failed");
        $finish;
    end

endmodule
